### src/slrg_pkg.sv
// constants, types and the generator step function for the shuffled lcg generator
// no dependencies; imported by shuffled_lcg_random_generator
package slrg_pkg;

    localparam int TABLE_SIZE   = 32;
    localparam int TBL_BITS     = $clog2(TABLE_SIZE);
    localparam int WARM_STEPS   = TABLE_SIZE + 8;
    localparam int CNT_BITS     = $clog2(WARM_STEPS);
    localparam int SAMPLE_BITS  = 31;

    localparam logic [14:0] LCG_MULT = 15'd16807;
    localparam logic [31:0] LCG_MOD  = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WARM  = 4'b0010,
        ST_DRAW  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    // 16807 * u mod (2^31 - 1), u in 0 .. 2^31; fold the bits from 31 up back in, then one subtract
    function automatic logic [31:0] lcg_advance(input logic [31:0] u);
        logic [46:0] prod;
        logic [31:0] fold;
        prod = u * LCG_MULT;
        fold = {16'd0, prod[46:31]} + {1'b0, prod[30:0]};
        if (fold >= LCG_MOD)
        begin
            fold = fold - LCG_MOD;
        end
        return fold;
    endfunction

endpackage

### src/shuffled_lcg_random_generator.sv
// shuffled lcg generator: minimal-standard multiplicative generator with a shuffle table
// the table sits in a synchronous memory with a registered read port
// depends on slrg_pkg
//
// plain draw: the input transfer is followed by the generator step with table read,
// then the table write-back with output load, held while the output is still full
// a new seed is taken only in ST_IDLE, once the previous item is loaded; a reseed first runs
// WARM_STEPS (40) generator steps, one generator step per cycle through the single multiplier
// reset: generator value and last sample clear to zero, so the first item reseeds;
// table contents are not cleared, every entry is written before a read of it is used
module shuffled_lcg_random_generator
    import slrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] sample, [31] zero
);

    logic [SAMPLE_BITS-1:0] mem [TABLE_SIZE];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    state_t                 state_reg, state_next;
    logic [31:0]            lcg_reg, lcg_next;
    logic [SAMPLE_BITS-1:0] last_reg, last_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [TBL_BITS-1:0]    slot_reg, slot_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;

    logic                   in_xfer;
    logic                   out_free;
    logic [31:0]            seed_eff;
    logic [31:0]            lcg_adv;
    logic                   need_init;
    logic                   wr_en;
    logic [TBL_BITS-1:0]    wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [TBL_BITS-1:0]    rd_addr;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, sample_reg};

    assign seed_eff  = (s_tdata != 32'd0) ? s_tdata : lcg_reg;
    assign need_init = $signed(seed_eff) <= 32'sd0 || last_reg == '0;
    assign lcg_adv   = lcg_advance(lcg_reg);
    // slot from the top bits of the previous sample
    assign rd_addr   = last_reg[SAMPLE_BITS-1 -: TBL_BITS];

    always_comb
    begin
        state_next    = state_reg;
        lcg_next      = lcg_reg;
        last_next     = last_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        sample_next   = sample_reg;
        m_tvalid_next = m_tvalid_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[TBL_BITS-1:0];
        wr_data       = lcg_adv[SAMPLE_BITS-1:0];

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (need_init)
                    begin
                        // magnitude of a negative value, else restart from 1
                        lcg_next   = $signed(seed_eff) < 32'sd0 ? (~seed_eff + 32'd1) : 32'd1;
                        cnt_next   = CNT_BITS'(WARM_STEPS - 1);
                        state_next = ST_WARM;
                    end
                    else
                    begin
                        lcg_next   = seed_eff;
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_WARM:
            begin
                lcg_next = lcg_adv;
                // the last TABLE_SIZE steps fill the table from the top slot down
                wr_en    = (cnt_reg < CNT_BITS'(TABLE_SIZE));
                cnt_next = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    last_next  = lcg_adv[SAMPLE_BITS-1:0];
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                lcg_next   = lcg_adv;
                slot_next  = rd_addr;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_addr = slot_reg;
                wr_data = lcg_reg[SAMPLE_BITS-1:0];
                if (out_free)
                begin
                    wr_en         = 1'b1;
                    sample_next   = rd_data_reg;
                    last_next     = rd_data_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lcg_reg      <= '0;
            last_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lcg_reg      <= lcg_next;
            last_reg     <= last_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        sample_reg <= sample_next;
    end

    // shuffle table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule
